// ===== rtl/control_sequencer_dispatch_core_macros.svh =====
// ----------------------------------------------------------------------------
// control_sequencer_dispatch_core_macros
// Assertion macros used by the checker file of the dispatch core.
// ----------------------------------------------------------------------------
`ifndef CONTROL_SEQUENCER_DISPATCH_CORE_MACROS_SVH
`define CONTROL_SEQUENCER_DISPATCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csd_pkg.sv =====
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the control sequencer dispatch core.
// ----------------------------------------------------------------------------
package csd_pkg;

    localparam int PROG_DEPTH = 256;
    localparam int SLOT_COUNT = 16;
    localparam int ADDR_W     = $clog2(PROG_DEPTH);
    localparam int PC_W       = $clog2(PROG_DEPTH + 1);
    localparam int SLOT_W     = 4;
    localparam int CONN_W     = 5;
    localparam int LEN_W      = 9;
    localparam int WAIT_W     = 27;
    localparam int PORT_W     = 9;
    localparam int WORD_W     = 32;

    localparam logic [1:0] KIND_FWD  = 2'd0;
    localparam logic [1:0] KIND_ACT  = 2'd1;
    localparam logic [1:0] KIND_HALT = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_OVERRUN = 3'd1;
    localparam logic [2:0] ERR_UNIMPL  = 3'd2;
    localparam logic [2:0] ERR_MODE    = 3'd3;
    localparam logic [2:0] ERR_SLOT    = 3'd4;

    localparam logic [2:0] OPC_HALT = 3'd0;
    localparam logic [2:0] OPC_WAIT = 3'd1;
    localparam logic [2:0] OPC_ACT  = 3'd2;
    localparam logic [2:0] OPC_CALC = 3'd3;
    localparam logic [2:0] OPC_BRN  = 3'd4;

    localparam logic [1:0] CFG_PROGRAM_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_CONNECTED_SLOTS = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACT,
        ST_FAIL
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  prog_len;
        logic [CONN_W-1:0] conn;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [PORT_W-1:0] port;
        logic [2:0]        err;
        logic              last;
    } result_t;

endpackage

// ===== rtl/csd_prog_mem.sv =====
// ----------------------------------------------------------------------------
// csd_prog_mem
// Program memory: one shared port, synchronous write, registered read.
// ----------------------------------------------------------------------------
module csd_prog_mem
(
    input  logic                      clk,
    input  csd_pkg::mem_req_t         req,
    output logic [csd_pkg::WORD_W-1:0] rdata
);

    logic [csd_pkg::WORD_W-1:0] mem [csd_pkg::PROG_DEPTH];
    logic [csd_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/csd_exec.sv =====
// ----------------------------------------------------------------------------
// csd_exec
// Sequencer: fetch, decode, activation fan-out and the result register.
// ----------------------------------------------------------------------------
module csd_exec
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_op,
    input  logic [7:0]                  in_addr,
    input  logic [csd_pkg::WORD_W-1:0]  in_word,
    input  csd_pkg::cfg_t               cfg,
    output csd_pkg::mem_req_t           mem_req,
    input  logic [csd_pkg::WORD_W-1:0]  mem_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output csd_pkg::result_t            out_res
);

    csd_pkg::state_t                state_reg, state_next;
    logic [csd_pkg::PC_W-1:0]       pc_reg, pc_next;
    logic [csd_pkg::WAIT_W-1:0]     wait_reg, wait_next;
    logic                           stopped_reg, stopped_next;
    logic [csd_pkg::SLOT_COUNT-1:0] mask_reg, mask_next;
    logic                           fixed_port_reg, fixed_port_next;
    logic [7:0]                     param_reg, param_next;
    logic [2:0]                     err_reg, err_next;
    logic                           out_valid_reg, out_valid_next;
    csd_pkg::result_t               res_reg;

    logic                           emit;
    csd_pkg::result_t               emit_res;
    logic                           out_free;
    logic [31:0]                    len_eff;
    logic [csd_pkg::CONN_W-1:0]     conn_eff;
    logic [31:0]                    load_addr_ext;
    logic [2:0]                     opc;
    logic [csd_pkg::SLOT_W-1:0]     word_slot;
    logic [csd_pkg::SLOT_COUNT-1:0] word_mask;
    logic [3:0]                     word_mode;
    logic [csd_pkg::SLOT_W-1:0]     act_idx;
    logic [csd_pkg::SLOT_COUNT-1:0] act_rest;

    assign out_free      = !out_valid_reg || out_ready;
    assign len_eff       = (32'(cfg.prog_len) > 32'(csd_pkg::PROG_DEPTH))
                           ? 32'(csd_pkg::PROG_DEPTH) : 32'(cfg.prog_len);
    assign conn_eff      = (cfg.conn > csd_pkg::CONN_W'(csd_pkg::SLOT_COUNT))
                           ? csd_pkg::CONN_W'(csd_pkg::SLOT_COUNT) : cfg.conn;
    assign load_addr_ext = 32'(in_addr);
    assign opc           = mem_rdata[30:28];
    assign word_slot     = mem_rdata[27:24];
    assign word_mask     = mem_rdata[12 +: csd_pkg::SLOT_COUNT];
    assign word_mode     = mem_rdata[11:8];

    // lowest pending activation
    always_comb
    begin
        act_idx = '0;
        for (int i = csd_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                act_idx = csd_pkg::SLOT_W'(i);
            end
        end
        act_rest          = mask_reg;
        act_rest[act_idx] = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        wait_next       = wait_reg;
        stopped_next    = stopped_reg;
        mask_next       = mask_reg;
        fixed_port_next = fixed_port_reg;
        param_next      = param_reg;
        err_next        = err_reg;
        emit            = 1'b0;
        emit_res        = '0;
        mem_req         = '0;
        in_ready        = 1'b0;

        case (state_reg)
            csd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_op)
                    begin
                        mem_req.wr_en = (load_addr_ext < 32'(csd_pkg::PROG_DEPTH));
                        mem_req.addr  = load_addr_ext[csd_pkg::ADDR_W-1:0];
                        mem_req.wdata = in_word;
                    end
                    else if (!stopped_reg)
                    begin
                        if (wait_reg != '0)
                        begin
                            wait_next = wait_reg - csd_pkg::WAIT_W'(1);
                        end
                        else if (32'(pc_reg) >= len_eff)
                        begin
                            err_next   = csd_pkg::ERR_OVERRUN;
                            mask_next  = '0;
                            state_next = csd_pkg::ST_FAIL;
                        end
                        else
                        begin
                            mem_req.rd_en = 1'b1;
                            mem_req.addr  = pc_reg[csd_pkg::ADDR_W-1:0];
                            state_next    = csd_pkg::ST_DECODE;
                        end
                    end
                end
            end

            csd_pkg::ST_DECODE:
            begin
                if (out_free)
                begin
                    state_next    = csd_pkg::ST_IDLE;
                    emit_res.last = 1'b1;
                    if (mem_rdata[31])
                    begin
                        emit = 1'b1;
                        if ({1'b0, word_slot} >= conn_eff)
                        begin
                            emit_res.kind = csd_pkg::KIND_ERR;
                            emit_res.err  = csd_pkg::ERR_SLOT;
                            emit_res.slot = word_slot;
                            stopped_next  = 1'b1;
                        end
                        else
                        begin
                            emit_res.kind = csd_pkg::KIND_FWD;
                            emit_res.slot = word_slot;
                            emit_res.word = mem_rdata;
                            pc_next       = pc_reg + csd_pkg::PC_W'(1);
                        end
                    end
                    else
                    begin
                        case (opc)
                            csd_pkg::OPC_HALT:
                            begin
                                emit          = 1'b1;
                                emit_res.kind = csd_pkg::KIND_HALT;
                                stopped_next  = 1'b1;
                                pc_next       = pc_reg + csd_pkg::PC_W'(1);
                            end
                            csd_pkg::OPC_WAIT:
                            begin
                                if (!mem_rdata[27])
                                begin
                                    wait_next = mem_rdata[csd_pkg::WAIT_W-1:0];
                                end
                                pc_next = pc_reg + csd_pkg::PC_W'(1);
                            end
                            csd_pkg::OPC_ACT:
                            begin
                                if (word_mask == '0)
                                begin
                                    pc_next = pc_reg + csd_pkg::PC_W'(1);
                                end
                                else if (word_mode > 4'd1)
                                begin
                                    emit          = 1'b1;
                                    emit_res.kind = csd_pkg::KIND_ERR;
                                    emit_res.err  = csd_pkg::ERR_MODE;
                                    stopped_next  = 1'b1;
                                end
                                else
                                begin
                                    mask_next       = word_mask;
                                    fixed_port_next = word_mode[0];
                                    param_next      = mem_rdata[7:0];
                                    state_next      = csd_pkg::ST_ACT;
                                end
                            end
                            csd_pkg::OPC_CALC, csd_pkg::OPC_BRN:
                            begin
                                emit          = 1'b1;
                                emit_res.kind = csd_pkg::KIND_ERR;
                                emit_res.err  = csd_pkg::ERR_UNIMPL;
                                stopped_next  = 1'b1;
                            end
                            default:
                            begin
                                pc_next = pc_reg + csd_pkg::PC_W'(1);
                            end
                        endcase
                    end
                end
            end

            csd_pkg::ST_ACT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if ({1'b0, act_idx} >= conn_eff)
                    begin
                        emit_res.kind = csd_pkg::KIND_ERR;
                        emit_res.err  = csd_pkg::ERR_SLOT;
                        emit_res.slot = act_idx;
                        emit_res.last = 1'b1;
                        stopped_next  = 1'b1;
                        state_next    = csd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        emit_res.kind = csd_pkg::KIND_ACT;
                        emit_res.slot = act_idx;
                        emit_res.port = fixed_port_reg ? csd_pkg::PORT_W'(param_reg)
                                        : csd_pkg::PORT_W'(param_reg)
                                          + csd_pkg::PORT_W'(act_idx);
                        emit_res.last = (act_rest == '0);
                        mask_next     = act_rest;
                        if (act_rest == '0)
                        begin
                            pc_next    = pc_reg + csd_pkg::PC_W'(1);
                            state_next = csd_pkg::ST_IDLE;
                        end
                    end
                end
            end

            csd_pkg::ST_FAIL:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    emit_res.kind = csd_pkg::KIND_ERR;
                    emit_res.err  = err_reg;
                    emit_res.last = 1'b1;
                    stopped_next  = 1'b1;
                    state_next    = csd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = csd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csd_pkg::ST_IDLE;
            pc_reg        <= '0;
            wait_reg      <= '0;
            stopped_reg   <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            wait_reg      <= wait_next;
            stopped_reg   <= stopped_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fixed_port_reg <= fixed_port_next;
        param_reg      <= param_next;
        err_reg        <= err_next;
        if (emit)
        begin
            res_reg <= emit_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/control_sequencer_dispatch_core.sv =====
// ----------------------------------------------------------------------------
// control_sequencer_dispatch_core
// Program-memory sequencer that forwards words to slots and fans out
// activations.
// ----------------------------------------------------------------------------
// A load request, a tick that counts down a wait and a tick arriving while
// the block is stopped are each taken and finished in the idle state. A tick
// that executes a word is accepted together with the program memory read,
// then decoded; an activation word that passes its mode check then fans out
// one result per cycle while the output is not stalled, activations and a
// closing slot error alike. A tick that finds pc at or past program_length
// passes through a fail state that emits the error. New ticks are taken only
// in the idle state. The single-port program memory serves loads and fetches
// with a registered read. Program memory is not cleared by reset and must be
// loaded before it is executed. Configuration writes are accepted every cycle.
module control_sequencer_dispatch_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // load_address[7:0], load_word[39:8]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // slot[3:0], instruction_word[35:4],
                                   // port[44:36], error_code[47:45]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    csd_pkg::cfg_t                 cfg_reg;
    csd_pkg::mem_req_t             mem_req;
    logic [csd_pkg::WORD_W-1:0]    mem_rdata;
    csd_pkg::result_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prog_len <= '0;
            cfg_reg.conn     <= csd_pkg::CONN_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                csd_pkg::CFG_PROGRAM_LENGTH:
                begin
                    cfg_reg.prog_len <= cfg_data;
                end
                csd_pkg::CFG_CONNECTED_SLOTS:
                begin
                    cfg_reg.conn <= cfg_data[csd_pkg::CONN_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    csd_prog_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    csd_exec u_exec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_addr   (s_tdata[7:0]),
        .in_word   (s_tdata[39:8]),
        .cfg       (cfg_reg),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {res.err, res.port, res.word, res.slot};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== rtl/csd_checker.sv =====
// ----------------------------------------------------------------------------
// csd_checker
// Port-level checks on the result stream of the dispatch core.
// ----------------------------------------------------------------------------
`include "control_sequencer_dispatch_core_macros.svh"

module csd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    `CSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled request changed")

    `CSD_ASSERT_NOW(a_stop_last, m_tvalid && (m_tuser == csd_pkg::KIND_HALT || m_tuser == csd_pkg::KIND_ERR), m_tlast, "halt or error request not marked last")

    `CSD_ASSERT_NOW(a_fwd_slot, m_tvalid && m_tuser == csd_pkg::KIND_FWD, m_tdata[35] && (m_tdata[3:0] == m_tdata[31:28]), "forwarded word does not match its slot")

    `CSD_ASSERT_NOW(a_err_clean, m_tvalid && m_tuser == csd_pkg::KIND_ERR, (m_tdata[44:4] == '0) && (m_tdata[47:45] != csd_pkg::ERR_NONE), "error request carries payload or no code")

endmodule

bind control_sequencer_dispatch_core csd_checker u_csd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
